// ----- design/mie_pkg.sv -----
package mie_pkg;

  localparam int unsigned ByteCount = 32;
  localparam int unsigned IndexBits = 11;
  localparam int unsigned ChecksumBits = 8;
  localparam int unsigned Rounds = 64;

  // Read request toward the entropy memory.
  typedef struct packed {
    logic       rd_en;
    logic [2:0] rd_addr;
  } mie_mem_req_t;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] PadWord = 32'h80000000;
  localparam logic [31:0] LenWord = 32'd256;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

// ----- design/mie_if.sv -----
interface mie_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] entropy_byte;
  modport source (output valid, output entropy_byte, input ready);
  modport sink (input valid, input entropy_byte, output ready);
endinterface

interface mie_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] word_index;
  logic        last_word;
  modport source (output valid, output word_index, output last_word, input ready);
  modport sink (input valid, input word_index, input last_word, output ready);
endinterface

// ----- design/mie_entropy_mem.sv -----
module mie_entropy_mem (
  input  logic                clk_i,
  input  logic                wr_en_i,
  input  logic [4:0]          byte_pos_i,
  input  logic [7:0]          byte_i,
  input  mie_pkg::mie_mem_req_t req_i,
  output logic [31:0]         rd_data_o
);

  logic [31:0] mem_q [8];
  logic [23:0] asm_q;
  logic [31:0] rd_data_q;

  // Gather three bytes, then write the full big-endian word with the fourth.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      asm_q <= {asm_q[15:0], byte_i};
      if (byte_pos_i[1:0] == 2'd3) begin
        mem_q[byte_pos_i[4:2]] <= {asm_q, byte_i};
      end
    end
  end

  // Synchronous read port.
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- design/mie_sha_core.sv -----
module mie_sha_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [31:0]           rd_data_i,
  output mie_pkg::mie_mem_req_t req_o,
  output logic                  done_o,
  output logic [7:0]            checksum_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_RND  = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [3:0]  ld_cnt_q, ld_cnt_d;
  logic [5:0]  rnd_q, rnd_d;
  logic        done_q, done_d;
  logic [7:0]  cs_q, cs_d;
  logic [31:0] w_q [16];
  logic [31:0] a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;
  logic [31:0] t1, t2, w_new, a_new;

  // Round datapath and next schedule word.
  always_comb begin
    t1 = h_q + mie_pkg::big_sigma1(e_q) + ((e_q & f_q) ^ (~e_q & g_q))
       + mie_pkg::RoundK[rnd_q] + w_q[0];
    t2 = mie_pkg::big_sigma0(a_q) + ((a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q));
    a_new = t1 + t2;
    w_new = w_q[0] + mie_pkg::small_sigma0(w_q[1]) + w_q[9]
          + mie_pkg::small_sigma1(w_q[14]);
  end

  // Sequencer: load eight words from memory, then run the rounds.
  always_comb begin
    state_d  = state_q;
    ld_cnt_d = ld_cnt_q;
    rnd_d    = rnd_q;
    done_d   = 1'b0;
    cs_d     = cs_q;
    req_o.rd_en   = 1'b0;
    req_o.rd_addr = ld_cnt_q[2:0];
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d  = S_LOAD;
          ld_cnt_d = 4'd0;
        end
      end
      S_LOAD: begin
        req_o.rd_en = !ld_cnt_q[3];
        ld_cnt_d    = ld_cnt_q + 4'd1;
        if (ld_cnt_q[3]) begin
          state_d = S_RND;
          rnd_d   = 6'd0;
        end
      end
      S_RND: begin
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == 6'(mie_pkg::Rounds - 1)) begin
          state_d = S_IDLE;
          done_d  = 1'b1;
          cs_d    = 8'((mie_pkg::InitH[0] + a_new) >> 24);
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ld_cnt_q <= '0;
      rnd_q    <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      ld_cnt_q <= ld_cnt_d;
      rnd_q    <= rnd_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cs_q <= cs_d;
  end

  // Schedule window and working variables.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) begin
      w_q[8] <= mie_pkg::PadWord;
      for (int i = 9; i < 15; i++) begin
        w_q[i] <= '0;
      end
      w_q[15] <= mie_pkg::LenWord;
      a_q <= mie_pkg::InitH[0];
      b_q <= mie_pkg::InitH[1];
      c_q <= mie_pkg::InitH[2];
      d_q <= mie_pkg::InitH[3];
      e_q <= mie_pkg::InitH[4];
      f_q <= mie_pkg::InitH[5];
      g_q <= mie_pkg::InitH[6];
      h_q <= mie_pkg::InitH[7];
    end else if (state_q == S_LOAD) begin
      if (ld_cnt_q != 4'd0) begin
        w_q[3'(ld_cnt_q - 4'd1)] <= rd_data_i;
      end
    end else if (state_q == S_RND) begin
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[15] <= w_new;
      h_q <= g_q;
      g_q <= f_q;
      f_q <= e_q;
      e_q <= d_q + t1;
      d_q <= c_q;
      c_q <= b_q;
      b_q <= a_q;
      a_q <= a_new;
    end
  end

  assign done_o     = done_q;
  assign checksum_o = cs_q;

endmodule

// ----- design/mnemonic_index_encoder_core.sv -----
// Channel  Dir  Payload                      Handshake
// in_i     in   entropy_byte[7:0]            valid/ready
// out_o    out  word_index[10:0], last_word  valid/ready
//
// Bytes 1 to 31 are taken back to back unless the output stalls; an index is emitted
// whenever 11 bits are packed. Byte 32 starts the hash: the block is loaded from the
// entropy memory (one word per read), the single round unit runs the rounds, then the
// checksum word goes to the output; only then is the next mnemonic's first byte taken.
// Reset clears all control state; no clearing pass is needed.
// Input stalls while a word waits in the output register and is not taken.
module mnemonic_index_encoder_core (
  input  logic     clk_i,
  input  logic     rst_ni,
  mie_in_if.sink   in_i,
  mie_out_if.source out_o
);

  localparam logic [1:0] ST_IN   = 2'd0;
  localparam logic [1:0] ST_HASH = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [4:0]  byte_cnt_q;
  logic [17:0] bit_buf_q;
  logic [4:0]  bit_fill_q;
  logic [2:0]  tail_q;
  logic [7:0]  cs_q;
  logic        out_valid_q;
  logic [10:0] out_index_q;
  logic        out_last_q;

  logic        out_free, in_fire, emit, last_byte;
  logic [17:0] buf_cat, buf_masked;
  logic [4:0]  fill_sum, fill_new;
  logic [10:0] emit_index;
  logic        sha_done;
  logic [7:0]  sha_cs;
  logic [31:0] mem_rd_data;
  mie_pkg::mie_mem_req_t mem_req;

  assign out_free  = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == ST_IN) && out_free;
  assign in_fire   = in_i.valid && in_i.ready;
  assign last_byte = byte_cnt_q == 5'(mie_pkg::ByteCount - 1);

  // Bit packing of the new byte.
  always_comb begin
    buf_cat    = {bit_buf_q[9:0], in_i.entropy_byte};
    fill_sum   = bit_fill_q + 5'd8;
    emit       = fill_sum >= 5'(mie_pkg::IndexBits);
    fill_new   = emit ? fill_sum - 5'(mie_pkg::IndexBits) : fill_sum;
    emit_index = 11'(buf_cat >> fill_new);
    buf_masked = buf_cat & ((18'd1 << fill_new) - 18'd1);
  end

  // Top-level sequence.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IN:   if (in_fire && last_byte) state_d = ST_HASH;
      ST_HASH: if (sha_done) state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IN;
      default: state_d = ST_IN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IN;
      byte_cnt_q  <= '0;
      bit_buf_q   <= '0;
      bit_fill_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        if (last_byte) begin
          byte_cnt_q <= '0;
          bit_buf_q  <= '0;
          bit_fill_q <= '0;
        end else begin
          byte_cnt_q <= byte_cnt_q + 5'd1;
          bit_buf_q  <= buf_masked;
          bit_fill_q <= fill_new;
        end
      end
      if (in_fire && emit) begin
        out_valid_q <= 1'b1;
      end else if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output word and checksum holding registers.
  always_ff @(posedge clk_i) begin
    if (in_fire && last_byte) begin
      tail_q <= buf_masked[2:0];
    end
    if (sha_done) begin
      cs_q <= sha_cs;
    end
    if (in_fire && emit) begin
      out_index_q <= emit_index;
      out_last_q  <= 1'b0;
    end else if (state_q == ST_DONE && out_free) begin
      out_index_q <= {tail_q, cs_q};
      out_last_q  <= 1'b1;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.word_index = out_index_q;
  assign out_o.last_word  = out_last_q;

  mie_entropy_mem u_mem (
    .clk_i      (clk_i),
    .wr_en_i    (in_fire),
    .byte_pos_i (byte_cnt_q),
    .byte_i     (in_i.entropy_byte),
    .req_i      (mem_req),
    .rd_data_o  (mem_rd_data)
  );

  mie_sha_core u_sha (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_fire && last_byte),
    .rd_data_i  (mem_rd_data),
    .req_o      (mem_req),
    .done_o     (sha_done),
    .checksum_o (sha_cs)
  );

endmodule

// ----- verif/tb_mnemonic_index_encoder_core.sv -----
module tb_mnemonic_index_encoder_core;

  typedef struct packed {
    logic [10:0] word_index;
    logic        last_word;
  } word_t;

  logic clk_i;
  logic rst_ni;

  mie_in_if  in_if ();
  mie_out_if out_if ();

  mnemonic_index_encoder_core uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Model state of the encoder.
  logic [4:0]  byte_cnt;
  logic [17:0] pack_buf;
  int unsigned pack_bits;
  logic [7:0]  entropy_bytes [32];

  word_t       expected_words [$];
  int unsigned error_count;
  int unsigned words_seen;
  int unsigned bytes_sent;
  int unsigned mnemonics_done;
  int unsigned idle_cycles;
  bit          stall_enable;

  // Clock.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic logic [31:0] rot_right(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // SHA-256 of the 32 stored bytes; returns the first digest word.
  function automatic logic [31:0] digest_first_word();
    logic [31:0] msg [64];
    logic [31:0] v [8];
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] sig0;
    logic [31:0] sig1;
    for (int i = 0; i < 8; i++) begin
      msg[i] = {entropy_bytes[4*i], entropy_bytes[4*i+1],
                entropy_bytes[4*i+2], entropy_bytes[4*i+3]};
    end
    msg[8] = mie_pkg::PadWord;
    for (int i = 9; i < 15; i++) msg[i] = '0;
    msg[15] = mie_pkg::LenWord;
    for (int i = 16; i < 64; i++) begin
      sig0 = rot_right(msg[i-15], 7) ^ rot_right(msg[i-15], 18) ^ (msg[i-15] >> 3);
      sig1 = rot_right(msg[i-2], 17) ^ rot_right(msg[i-2], 19) ^ (msg[i-2] >> 10);
      msg[i] = msg[i-16] + sig0 + msg[i-7] + sig1;
    end
    for (int i = 0; i < 8; i++) v[i] = mie_pkg::InitH[i];
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (rot_right(v[4], 6) ^ rot_right(v[4], 11) ^ rot_right(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + mie_pkg::RoundK[r] + msg[r];
      t2 = (rot_right(v[0], 2) ^ rot_right(v[0], 13) ^ rot_right(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    return mie_pkg::InitH[0] + v[0];
  endfunction

  // Predict the words caused by one accepted byte.
  task automatic predict_words(input logic [7:0] b);
    word_t       w;
    logic [31:0] digest;
    entropy_bytes[byte_cnt] = b;
    pack_buf  = {pack_buf[9:0], b};
    pack_bits = pack_bits + 8;
    if (pack_bits >= mie_pkg::IndexBits) begin
      pack_bits = pack_bits - mie_pkg::IndexBits;
      w.word_index = 11'(pack_buf >> pack_bits);
      w.last_word  = 1'b0;
      expected_words = {expected_words, w};
      pack_buf = pack_buf & ((18'd1 << pack_bits) - 18'd1);
    end
    if (byte_cnt == 5'd31) begin
      digest = digest_first_word();
      w.word_index = {pack_buf[2:0], digest[31:24]};
      w.last_word  = 1'b1;
      expected_words = {expected_words, w};
      byte_cnt  = '0;
      pack_buf  = '0;
      pack_bits = 0;
      mnemonics_done++;
    end else begin
      byte_cnt = byte_cnt + 5'd1;
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("mismatch at word %0d: %s", words_seen, what);
    error_count++;
  endtask

  // Send one byte, with a random gap before it when gaps are on.
  task automatic send_byte(input logic [7:0] b, input bit gap);
    int unsigned wait_cycles;
    wait_cycles = gap ? $urandom_range(0, 4) : 0;
    if ($urandom_range(0, 3) != 0) wait_cycles = 0;
    if (wait_cycles != 0) begin
      in_if.valid <= 1'b0;
      repeat (wait_cycles) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.entropy_byte <= b;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predict_words(b);
    bytes_sent++;
  endtask

  // Drop valid for one cycle.
  task automatic release_input();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Receiver stall pattern and result checker.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("word with none expected");
        end else begin
          word_t w;
          w = expected_words.pop_front();
          if (out_if.word_index !== w.word_index)
            report_mismatch($sformatf("index %0d, expected %0d",
                                      out_if.word_index, w.word_index));
          if (out_if.last_word !== w.last_word)
            report_mismatch($sformatf("last flag %0b, expected %0b",
                                      out_if.last_word, w.last_word));
        end
        words_seen++;
      end
      out_if.ready <= stall_enable ? (($urandom_range(0, 7) > 2) ? 1'b1 : 1'b0) : 1'b1;
    end
  end

  // Watchdog over cycles with no accepted byte at the input and no accepted word at the output.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic send_mnemonic_const(input logic [7:0] b);
    for (int i = 0; i < 32; i++) send_byte(b, 1'b0);
  endtask

  // Extremes: all zeros, all ones, alternating bits, counting bytes.
  task automatic test_directed();
    send_mnemonic_const(8'h00);
    send_mnemonic_const(8'hff);
    for (int i = 0; i < 32; i++) send_byte((i % 2) ? 8'h55 : 8'haa, 1'b0);
    for (int i = 0; i < 32; i++) send_byte(8'(i), 1'b1);
    release_input();
  endtask

  // Random mnemonics under bursts, gaps and output stalls.
  task automatic test_random();
    stall_enable = 1'b1;
    for (int m = 0; m < 50; m++) begin
      if (m % 10 == 9) stall_enable = ~stall_enable;
      for (int i = 0; i < 32; i++) send_byte(8'($urandom_range(0, 255)), m % 3 != 0);
      if ($urandom_range(0, 1)) release_input();
    end
    // A partial mnemonic is finished by the next one; end on a boundary.
    release_input();
  endtask

  task automatic drain_words();
    int unsigned n;
    n = 0;
    while (expected_words.size() != 0 && n < 20000) begin
      @(posedge clk_i);
      n++;
    end
    repeat (200) @(posedge clk_i);
  endtask

  initial begin
    byte_cnt = '0; pack_buf = '0; pack_bits = 0;
    error_count = 0; words_seen = 0; bytes_sent = 0; mnemonics_done = 0;
    idle_cycles = 0;
    stall_enable = 1'b0;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.entropy_byte = '0;
    out_if.ready = 1'b1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random();
    drain_words();
    $display("Sent %0d entropy bytes forming %0d mnemonics; checked %0d indices.",
             bytes_sent, mnemonics_done, words_seen);
    if (error_count == 0 && expected_words.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/mie_pkg.sv
design/mie_if.sv
design/mie_entropy_mem.sv
design/mie_sha_core.sv
design/mnemonic_index_encoder_core.sv
verif/tb_mnemonic_index_encoder_core.sv
